FILE: rtl/fr_pkg.sv
package fr_pkg;

  localparam int FR_W  = 32;
  localparam int FR_KW = $clog2(FR_W);

  localparam logic [FR_W-1:0] FR_MIN = {1'b1, {(FR_W-1){1'b0}}};

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ZERO_DEN = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  typedef struct packed {
    logic signed [FR_W-1:0] numerator_in;
    logic signed [FR_W-1:0] denominator_in;
  } fr_in_t;

  typedef struct packed {
    logic signed [FR_W-1:0] numerator_out;
    logic        [FR_W-2:0] denominator_out;
    logic        [1:0]      status;
  } fr_out_t;

endpackage

FILE: rtl/fr_bgcd.sv
module fr_bgcd (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [fr_pkg::FR_W-1:0] a,
  input  logic [fr_pkg::FR_W-1:0] b,
  output logic                    done,
  output logic [fr_pkg::FR_W-1:0] g
);

  logic                     run_r, run_nxt;
  logic                     cmn_r, cmn_nxt;
  logic                     done_r, done_nxt;
  logic [fr_pkg::FR_W-1:0]  x_r, x_nxt;
  logic [fr_pkg::FR_W-1:0]  y_r, y_nxt;
  logic [fr_pkg::FR_W-1:0]  g_r, g_nxt;
  logic [fr_pkg::FR_KW-1:0] k_r, k_nxt;
  logic                     x_gt;
  logic [fr_pkg::FR_W-1:0]  diff;

  assign x_gt = x_r > y_r;
  assign diff = x_gt ? (x_r - y_r) : (y_r - x_r);

  always_comb begin
    run_nxt  = run_r;
    cmn_nxt  = cmn_r;
    done_nxt = 1'b0;
    x_nxt    = x_r;
    y_nxt    = y_r;
    g_nxt    = g_r;
    k_nxt    = k_r;
    if (start) begin
      x_nxt   = a;
      y_nxt   = b;
      k_nxt   = '0;
      run_nxt = 1'b1;
      cmn_nxt = 1'b1;
    end else if (run_r) begin
      if (cmn_r && !x_r[0] && !y_r[0]) begin
        x_nxt = x_r >> 1;
        y_nxt = y_r >> 1;
        k_nxt = k_r + fr_pkg::FR_KW'(1);
      end else begin
        cmn_nxt = 1'b0;
        if (!x_r[0]) begin
          x_nxt = x_r >> 1;
        end else if (!y_r[0]) begin
          y_nxt = y_r >> 1;
        end else if (x_r == y_r) begin
          run_nxt  = 1'b0;
          done_nxt = 1'b1;
          g_nxt    = x_r << k_r;
        end else if (x_gt) begin
          x_nxt = diff;
        end else begin
          y_nxt = diff;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      cmn_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      cmn_r  <= cmn_nxt;
      done_r <= done_nxt;
    end
    x_r <= x_nxt;
    y_r <= y_nxt;
    g_r <= g_nxt;
    k_r <= k_nxt;
  end

  assign done = done_r;
  assign g    = g_r;

endmodule

FILE: rtl/fr_div.sv
module fr_div (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [fr_pkg::FR_W-1:0] dividend,
  input  logic [fr_pkg::FR_W-1:0] divisor,
  output logic                    done,
  output logic [fr_pkg::FR_W-1:0] quotient
);

  logic                     run_r, run_nxt;
  logic                     done_r, done_nxt;
  logic [fr_pkg::FR_KW-1:0] cnt_r, cnt_nxt;
  logic [fr_pkg::FR_W-1:0]  rem_r, rem_nxt;
  logic [fr_pkg::FR_W-1:0]  quo_r, quo_nxt;
  logic [fr_pkg::FR_W-1:0]  dvs_r, dvs_nxt;
  logic [fr_pkg::FR_W:0]    shifted;
  logic [fr_pkg::FR_W:0]    trial;
  logic                     fits;

  assign shifted = {rem_r, quo_r[fr_pkg::FR_W-1]};
  assign trial   = shifted - {1'b0, dvs_r};
  assign fits    = !trial[fr_pkg::FR_W];

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      run_nxt = 1'b1;
      cnt_nxt = fr_pkg::FR_KW'(fr_pkg::FR_W - 1);
      rem_nxt = '0;
      quo_nxt = dividend;
      dvs_nxt = divisor;
    end else if (run_r) begin
      rem_nxt = fits ? trial[fr_pkg::FR_W-1:0] : shifted[fr_pkg::FR_W-1:0];
      quo_nxt = {quo_r[fr_pkg::FR_W-2:0], fits};
      if (cnt_r == '0) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - fr_pkg::FR_KW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

FILE: rtl/fraction_reduce_gcd_top.sv
// Reduces a signed fraction to lowest terms, with the sign moved to the numerator.
// Input: a transfer takes place at a clock edge where start is high and busy is low;
// in_data carries the numerator and the denominator as two's complement words.
// Output: each result is shown on out_data for exactly one cycle while out_valid
// is high. The receiver cannot stall the block, so it must take every result then.
// A zero denominator gives status 1, the most negative denominator or a reduced
// numerator that does not fit gives status 2; both return zero outputs.
// A zero denominator, the most negative denominator or a zero numerator gives its
// result in the cycle after the transfer, and busy stays low; a zero numerator
// keeps the magnitude of the denominator. Any other item keeps busy high while
// a binary gcd runs on its compare and subtract unit, one shift or subtraction
// per cycle, followed by two restoring divisions on one shared divider.
// Busy falls in the cycle where the result is shown, so the next item can be
// started then. Reset clears the sequencer and drops busy and out_valid.
module fraction_reduce_gcd_top (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  fr_pkg::fr_in_t  in_data,
  output logic            out_valid,
  output fr_pkg::fr_out_t out_data
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_GCD  = 2'd1;
  localparam logic [1:0] S_DIVN = 2'd2;
  localparam logic [1:0] S_DIVD = 2'd3;

  logic [1:0]              state_r, state_nxt;
  logic                    out_valid_r, out_valid_nxt;
  fr_pkg::fr_out_t         out_data_r, out_data_nxt;
  logic [fr_pkg::FR_W-1:0] mn_r, mn_nxt;
  logic [fr_pkg::FR_W-1:0] md_r, md_nxt;
  logic [fr_pkg::FR_W-1:0] g_r, g_nxt;
  logic [fr_pkg::FR_W-1:0] rn_r, rn_nxt;
  logic                    neg_r, neg_nxt;

  logic                    accept;
  logic [fr_pkg::FR_W-1:0] a_u, b_u, mag_a, mag_b;
  logic                    gcd_start, gcd_done;
  logic [fr_pkg::FR_W-1:0] gcd_g;
  logic                    div_start, div_done;
  logic [fr_pkg::FR_W-1:0] div_dividend, div_divisor, div_q;

  assign busy   = state_r != S_IDLE;
  assign accept = start && !busy;
  assign a_u    = in_data.numerator_in;
  assign b_u    = in_data.denominator_in;
  assign mag_a  = a_u[fr_pkg::FR_W-1] ? (~a_u + fr_pkg::FR_W'(1)) : a_u;
  assign mag_b  = b_u[fr_pkg::FR_W-1] ? (~b_u + fr_pkg::FR_W'(1)) : b_u;

  assign div_dividend = (state_r == S_GCD) ? mn_r  : md_r;
  assign div_divisor  = (state_r == S_GCD) ? gcd_g : g_r;

  fr_bgcd u_gcd (
    .clk   (clk),
    .rst_n (rst_n),
    .start (gcd_start),
    .a     (mag_a),
    .b     (mag_b),
    .done  (gcd_done),
    .g     (gcd_g)
  );

  fr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    mn_nxt        = mn_r;
    md_nxt        = md_r;
    g_nxt         = g_r;
    rn_nxt        = rn_r;
    neg_nxt       = neg_r;
    gcd_start     = 1'b0;
    div_start     = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (b_u == '0) begin
            out_valid_nxt                = 1'b1;
            out_data_nxt.numerator_out   = '0;
            out_data_nxt.denominator_out = '0;
            out_data_nxt.status          = fr_pkg::ST_ZERO_DEN;
          end else if (b_u == fr_pkg::FR_MIN) begin
            out_valid_nxt                = 1'b1;
            out_data_nxt.numerator_out   = '0;
            out_data_nxt.denominator_out = '0;
            out_data_nxt.status          = fr_pkg::ST_OVERFLOW;
          end else if (mag_a == '0) begin
            out_valid_nxt                = 1'b1;
            out_data_nxt.numerator_out   = '0;
            out_data_nxt.denominator_out = mag_b[fr_pkg::FR_W-2:0];
            out_data_nxt.status          = fr_pkg::ST_OK;
          end else begin
            gcd_start = 1'b1;
            mn_nxt    = mag_a;
            md_nxt    = mag_b;
            neg_nxt   = a_u[fr_pkg::FR_W-1] ^ b_u[fr_pkg::FR_W-1];
            state_nxt = S_GCD;
          end
        end
      end
      S_GCD: begin
        if (gcd_done) begin
          g_nxt     = gcd_g;
          div_start = 1'b1;
          state_nxt = S_DIVN;
        end
      end
      S_DIVN: begin
        if (div_done) begin
          rn_nxt    = div_q;
          div_start = 1'b1;
          state_nxt = S_DIVD;
        end
      end
      S_DIVD: begin
        if (div_done) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          if (!neg_r && rn_r[fr_pkg::FR_W-1]) begin
            out_data_nxt.numerator_out   = '0;
            out_data_nxt.denominator_out = '0;
            out_data_nxt.status          = fr_pkg::ST_OVERFLOW;
          end else begin
            out_data_nxt.numerator_out   = neg_r ? (~rn_r + fr_pkg::FR_W'(1)) : rn_r;
            out_data_nxt.denominator_out = div_q[fr_pkg::FR_W-2:0];
            out_data_nxt.status          = fr_pkg::ST_OK;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
    mn_r       <= mn_nxt;
    md_r       <= md_nxt;
    g_r        <= g_nxt;
    rn_r       <= rn_nxt;
    neg_r      <= neg_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_valid_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while an item is still in progress");

  a_gcd_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    gcd_done |-> (state_r == S_GCD))
    else $error("gcd finished outside the gcd phase");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> ((state_r == S_DIVN) || (state_r == S_DIVD)))
    else $error("divider finished outside a division phase");

  a_ok_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status == fr_pkg::ST_OK)) |-> (out_data.denominator_out != '0))
    else $error("good result with a zero denominator");

endmodule
